[design/partition_fit_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Partition fit allocator assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PFA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("partition fit allocator: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PFA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("partition fit allocator: next-cycle check failed");

`endif

[design/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// Partition fit allocator package
// Shared types, register codes and defaults of the partition fit allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

   localparam int NUM_PARTITIONS_DEFAULT = 8;
   localparam int SIZE_WIDTH_DEFAULT     = 16;

   localparam int PART_INDEX_W = 3;
   localparam int AMOUNT_W     = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 4;
   localparam int COUNT_W      = 4;

   localparam logic KIND_LOAD    = 1'b0;
   localparam logic KIND_REQUEST = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_MODE        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PARTITION_COUNT = 2'd1;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2
   } fit_mode_type;

   localparam logic [1:0]         FIT_MODE_RESET = 2'd0;
   localparam logic [COUNT_W-1:0] COUNT_RESET    = 4'd8;

   typedef struct packed {
      logic                    kind;
      logic [PART_INDEX_W-1:0] partition_index;
      logic [AMOUNT_W-1:0]     amount;
   } req_type;

   typedef struct packed {
      logic                    granted;
      logic [PART_INDEX_W-1:0] chosen_partition;
      logic [AMOUNT_W-1:0]     capacity_left;
   } rsp_type;

   // Commands broadcast from the sequencer to every cell.
   typedef struct packed {
      logic                    load_en;
      logic [PART_INDEX_W-1:0] load_index;
      logic                    update_en;
      fit_mode_type            mode;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[design/pfa_cell.sv]
// ----------------------------------------------------------------------------
// Partition fit allocator cell
// Holds one partition's remaining capacity and refines the passing search
// token against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_cell #(
   parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEFAULT,
   parameter int SIZE_WIDTH     = pfa_pkg::SIZE_WIDTH_DEFAULT,
   parameter int CELL_INDEX     = 0
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire pfa_pkg::cell_ctrl_type                  ctrl,
   input  wire logic [SIZE_WIDTH-1:0]                   load_value,
   input  wire logic [SIZE_WIDTH-1:0]                   req_amount,
   input  wire logic [$clog2(NUM_PARTITIONS+1)-1:0]     used,
   input  wire logic [$clog2(NUM_PARTITIONS)-1:0]       upd_pick,
   input  wire logic                                    tok_valid_in,
   input  wire logic                                    tok_found_in,
   input  wire logic [$clog2(NUM_PARTITIONS)-1:0]       tok_pick_in,
   input  wire logic [SIZE_WIDTH-1:0]                   tok_best_in,
   output      logic                                    tok_valid_out,
   output      logic                                    tok_found_out,
   output      logic [$clog2(NUM_PARTITIONS)-1:0]       tok_pick_out,
   output      logic [SIZE_WIDTH-1:0]                   tok_best_out
);

   localparam int IDX_W = $clog2(NUM_PARTITIONS);
   localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
   // Only partitions reachable through the three-bit load index can be loaded.
   localparam bit LOADABLE = (CELL_INDEX < (1 << pfa_pkg::PART_INDEX_W));

   logic [SIZE_WIDTH-1:0] cap_ff, cap_in;
   logic                  valid_ff, found_ff, found_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [SIZE_WIDTH-1:0] best_ff, best_in;
   logic                  load_hit, upd_hit, in_use, fits, better, take;

   always_comb begin
      load_hit = LOADABLE && ctrl.load_en &&
                 (ctrl.load_index == pfa_pkg::PART_INDEX_W'(CELL_INDEX));
      upd_hit  = ctrl.update_en && (upd_pick == IDX_W'(CELL_INDEX));
      in_use   = CNT_W'(CELL_INDEX) < used;
      fits     = cap_ff >= req_amount;
      unique case (ctrl.mode)
         pfa_pkg::FIT_FIRST: better = !tok_found_in;
         pfa_pkg::FIT_BEST:  better = !tok_found_in || (cap_ff < tok_best_in);
         pfa_pkg::FIT_WORST: better = !tok_found_in || (cap_ff > tok_best_in);
         default:            better = 1'b0;
      endcase
      take     = tok_valid_in && in_use && fits && better;
      found_in = tok_found_in || take;
      pick_in  = take ? IDX_W'(CELL_INDEX) : tok_pick_in;
      best_in  = take ? cap_ff : tok_best_in;

      // A load issued together with a write-back belongs to the later transaction.
      priority if (load_hit) begin
         cap_in = load_value;
      end else if (upd_hit) begin
         cap_in = cap_ff - req_amount;
      end else begin
         cap_in = cap_ff;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      pick_ff  <= pick_in;
      best_ff  <= best_in;
      if (reset) begin
         cap_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cap_ff   <= cap_in;
         valid_ff <= tok_valid_in;
      end
   end

   assign tok_valid_out = valid_ff;
   assign tok_found_out = found_ff;
   assign tok_pick_out  = pick_ff;
   assign tok_best_out  = best_ff;

endmodule

`default_nettype wire

[design/pfa_seq.sv]
// ----------------------------------------------------------------------------
// Partition fit allocator sequencer
// Holds the configuration registers, launches the search token, collects it
// at the end of the cell row and issues the write-back and the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_seq #(
   parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEFAULT,
   parameter int SIZE_WIDTH     = pfa_pkg::SIZE_WIDTH_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output      logic                                    busy,
   input  wire pfa_pkg::req_type                        req_data,
   output      logic                                    rsp_valid,
   output      pfa_pkg::rsp_type                        rsp_data,
   input  wire logic                                    csr_valid,
   output      logic                                    csr_ready,
   input  wire logic [pfa_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [pfa_pkg::CSR_DATA_W-1:0]          csr_data,
   output      pfa_pkg::cell_ctrl_type                  ctrl,
   output      logic [SIZE_WIDTH-1:0]                   load_value,
   output      logic [SIZE_WIDTH-1:0]                   req_amount,
   output      logic [$clog2(NUM_PARTITIONS+1)-1:0]     used,
   output      logic [$clog2(NUM_PARTITIONS)-1:0]       upd_pick,
   output      logic                                    head_valid,
   input  wire logic                                    tail_valid,
   input  wire logic                                    tail_found,
   input  wire logic [$clog2(NUM_PARTITIONS)-1:0]       tail_pick,
   input  wire logic [SIZE_WIDTH-1:0]                   tail_best
);

   localparam int IDX_W = $clog2(NUM_PARTITIONS);
   localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                     state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pfa_pkg::rsp_type              rsp_ff, rsp_in;
   logic                          upd_en_ff, upd_en_in;
   logic [IDX_W-1:0]              upd_pick_ff, upd_pick_in;
   logic                          inject_ff, inject_in;
   logic [SIZE_WIDTH-1:0]         amount_ff, amount_in;
   logic [1:0]                    mode_ff, mode_in;
   logic [CNT_W-1:0]              used_ff, used_in;
   logic [1:0]                    fit_mode_ff, fit_mode_in;
   logic [pfa_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          load_en;
   logic [SIZE_WIDTH-1:0]         diff;
   logic [CNT_W-1:0]              used_sat;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      upd_en_in    = 1'b0;
      upd_pick_in  = upd_pick_ff;
      inject_in    = 1'b0;
      amount_in    = amount_ff;
      mode_in      = mode_ff;
      used_in      = used_ff;
      fit_mode_in  = fit_mode_ff;
      count_in     = count_ff;
      load_en      = 1'b0;
      diff         = tail_best - amount_ff;

      if (int'(count_ff) > NUM_PARTITIONS) begin
         used_sat = CNT_W'(NUM_PARTITIONS);
      end else begin
         used_sat = CNT_W'(count_ff);
      end

      if (csr_valid) begin
         unique case (csr_index)
            pfa_pkg::CSR_FIT_MODE: begin
               fit_mode_in = csr_data[1:0];
            end
            pfa_pkg::CSR_PARTITION_COUNT: begin
               count_in = csr_data;
            end
            default: begin
               // Writes to unassigned indices are dropped.
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.kind == pfa_pkg::KIND_REQUEST) begin
                  state_in  = ST_SCAN;
                  inject_in = 1'b1;
                  amount_in = SIZE_WIDTH'(req_data.amount);
                  mode_in   = fit_mode_ff;
                  used_in   = used_sat;
               end else begin
                  load_en = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (tail_valid) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               upd_en_in    = tail_found;
               upd_pick_in  = tail_pick;
               if (tail_found) begin
                  rsp_in.granted          = 1'b1;
                  rsp_in.chosen_partition = pfa_pkg::PART_INDEX_W'(tail_pick);
                  rsp_in.capacity_left    = pfa_pkg::AMOUNT_W'(diff);
               end else begin
                  rsp_in = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff      <= rsp_in;
      upd_pick_ff <= upd_pick_in;
      amount_ff   <= amount_in;
      mode_ff     <= mode_in;
      used_ff     <= used_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         upd_en_ff    <= 1'b0;
         inject_ff    <= 1'b0;
         fit_mode_ff  <= pfa_pkg::FIT_MODE_RESET;
         count_ff     <= pfa_pkg::COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         upd_en_ff    <= upd_en_in;
         inject_ff    <= inject_in;
         fit_mode_ff  <= fit_mode_in;
         count_ff     <= count_in;
      end
   end

   always_comb begin
      ctrl.load_en    = load_en;
      ctrl.load_index = req_data.partition_index;
      ctrl.update_en  = upd_en_ff;
      ctrl.mode       = pfa_pkg::fit_mode_type'(mode_ff);
   end

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign load_value = SIZE_WIDTH'(req_data.amount);
   assign req_amount = amount_ff;
   assign used       = used_ff;
   assign upd_pick   = upd_pick_ff;
   assign head_valid = inject_ff;

endmodule

`default_nettype wire

[design/partition_fit_allocator.sv]
// ----------------------------------------------------------------------------
// Partition fit allocator
// Keeps the remaining capacity of each memory partition and answers each
// allocation request with first, best or worst fit. A load transaction writes
// one partition's capacity in the cycle it is accepted and gives no response;
// the block stays free, so the next transaction may follow at once. A request
// transaction raises busy until its search is done, and no new transaction is
// taken while busy is high. The search token walks the row of partition cells
// one cell per cycle. The response is marked by rsp_valid, high for a single
// cycle, in the cycle in which busy falls, and is held on rsp_data after that;
// the receiver cannot stall it and must take it then. Configuration is written
// through the csr port, which is always ready; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module partition_fit_allocator #(
   parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEFAULT,
   parameter int SIZE_WIDTH     = pfa_pkg::SIZE_WIDTH_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output      logic                            busy,
   input  wire pfa_pkg::req_type                req_data,
   output      logic                            rsp_valid,
   output      pfa_pkg::rsp_type                rsp_data,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [pfa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [pfa_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(NUM_PARTITIONS);
   localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

   // Broadcast controls from the sequencer to every cell.
   pfa_pkg::cell_ctrl_type ctrl;
   logic [SIZE_WIDTH-1:0]  load_value;
   logic [SIZE_WIDTH-1:0]  req_amount;
   logic [CNT_W-1:0]       used;
   logic [IDX_W-1:0]       upd_pick;

   // The search token between neighbouring cells. Entry 0 is launched by the
   // sequencer and entry NUM_PARTITIONS is the verdict coming off the row.
   logic                   tok_valid [NUM_PARTITIONS+1];
   logic                   tok_found [NUM_PARTITIONS+1];
   logic [IDX_W-1:0]       tok_pick  [NUM_PARTITIONS+1];
   logic [SIZE_WIDTH-1:0]  tok_best  [NUM_PARTITIONS+1];

   // The token starts empty: nothing found yet, so the first fitting
   // partition in use always takes it.
   assign tok_found[0] = 1'b0;
   assign tok_pick[0]  = '0;
   assign tok_best[0]  = '0;

   pfa_seq #(
      .NUM_PARTITIONS(NUM_PARTITIONS),
      .SIZE_WIDTH    (SIZE_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .ctrl       (ctrl),
      .load_value (load_value),
      .req_amount (req_amount),
      .used       (used),
      .upd_pick   (upd_pick),
      .head_valid (tok_valid[0]),
      .tail_valid (tok_valid[NUM_PARTITIONS]),
      .tail_found (tok_found[NUM_PARTITIONS]),
      .tail_pick  (tok_pick[NUM_PARTITIONS]),
      .tail_best  (tok_best[NUM_PARTITIONS])
   );

   // The row of cells. Each cell owns one capacity; the token passes from
   // lower to higher index, so on equal capacities the lower index, seen
   // first, keeps the token under the strict comparisons of best and worst
   // fit. The write-back to the chosen cell happens in the cycle after the
   // response is registered.
   for (genvar k = 0; k < NUM_PARTITIONS; k++) begin : g_cell
      pfa_cell #(
         .NUM_PARTITIONS(NUM_PARTITIONS),
         .SIZE_WIDTH    (SIZE_WIDTH),
         .CELL_INDEX    (k)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .load_value    (load_value),
         .req_amount    (req_amount),
         .used          (used),
         .upd_pick      (upd_pick),
         .tok_valid_in  (tok_valid[k]),
         .tok_found_in  (tok_found[k]),
         .tok_pick_in   (tok_pick[k]),
         .tok_best_in   (tok_best[k]),
         .tok_valid_out (tok_valid[k+1]),
         .tok_found_out (tok_found[k+1]),
         .tok_pick_out  (tok_pick[k+1]),
         .tok_best_out  (tok_best[k+1])
      );
   end

endmodule

`default_nettype wire

[design/pfa_checker.sv]
// ----------------------------------------------------------------------------
// Partition fit allocator port checker
// Checks the timing of busy and responses and the contents of refusals on the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "partition_fit_allocator_defines.svh"

module pfa_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire pfa_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire pfa_pkg::rsp_type rsp_data
);

   // A response appears exactly when a request finishes.
   `PFA_ASSERT_IMP(a_rsp_ends_busy, clock, reset, rsp_valid, !busy && $past(busy))
   `PFA_ASSERT_IMP(a_busy_end_has_rsp, clock, reset, $fell(busy), rsp_valid)
   // A request occupies the block; a load does not.
   `PFA_ASSERT_NXT(a_req_sets_busy, clock, reset,
      start && !busy && (req_data.kind == pfa_pkg::KIND_REQUEST), busy)
   `PFA_ASSERT_NXT(a_load_stays_free, clock, reset,
      start && !busy && (req_data.kind == pfa_pkg::KIND_LOAD), !busy && !rsp_valid)
   // A refusal carries no partition and no capacity.
   `PFA_ASSERT_IMP(a_refusal_zero, clock, reset, rsp_valid && !rsp_data.granted,
      (rsp_data.chosen_partition == '0) && (rsp_data.capacity_left == '0))

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire
